// ----- hw/rtl/gtl_pkg.sv -----
// Shared types and constants for the 3D grid trilinear sampler.
// No dependencies; imported by gtl_agen, gtl_lerp and the top level in hw/rtl.
package gtl_pkg;

    // Default build values
    localparam int MAX_DIM_DEF   = 32;
    localparam int FRAC_BITS_DEF = 8;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 2'd2;
    localparam logic [CFG_DATA_W-1:0] SIZE_RESET = 6'd32;

    // Item function codes
    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    // Store word widths
    localparam int DENS_W = 16;
    localparam int ATTR_W = 24;   // {material, zone}

    // Read slots per sample: eight corners, then the nearest cell
    localparam int SLOT_W = 4;
    localparam logic [SLOT_W-1:0] SLOT_NEAREST = 4'd8;

    typedef struct packed {
        logic               func;
        logic [14:0]        cell_index;
        logic signed [15:0] write_density;
        logic [7:0]         write_material;
        logic signed [15:0] write_zone;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
    } t_gtl_in;

    typedef struct packed {
        logic signed [15:0] density;
        logic [7:0]         material;
        logic signed [15:0] zone;
    } t_gtl_out;

    // Tag that travels with an address through the read pipe
    typedef struct packed {
        logic valid;
        logic nearest;
    } t_gtl_slot;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_DONE
    } t_gtl_state;

endpackage

// ----- hw/rtl/gtl_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module gtl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/gtl_agen.sv -----
// Address generator: (z*size_y + y)*size_x + x over two multiply stages.
// Depends on gtl_pkg for the slot tag type.
module gtl_agen #(
    parameter int MAX_DIM = gtl_pkg::MAX_DIM_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  gtl_pkg::t_gtl_slot                          i_slot,
    input  logic [$clog2(MAX_DIM)-1:0]                  i_x,
    input  logic [$clog2(MAX_DIM)-1:0]                  i_y,
    input  logic [$clog2(MAX_DIM)-1:0]                  i_z,
    input  logic [$clog2(MAX_DIM+1)-1:0]                i_size_x,
    input  logic [$clog2(MAX_DIM+1)-1:0]                i_size_y,
    output gtl_pkg::t_gtl_slot                          o_slot,
    output logic [$clog2(MAX_DIM*MAX_DIM*MAX_DIM)-1:0]  o_addr
);
    import gtl_pkg::*;

    localparam int CO_W = $clog2(MAX_DIM);
    localparam int SZ_W = $clog2(MAX_DIM + 1);
    localparam int ZY_W = $clog2(MAX_DIM * MAX_DIM);
    localparam int AW   = $clog2(MAX_DIM * MAX_DIM * MAX_DIM);
    localparam int PA_W = CO_W + SZ_W + 1;
    localparam int PB_W = ZY_W + SZ_W + 1;

    t_gtl_slot        r_slot_a, r_slot_b;
    logic [ZY_W-1:0]  r_zy;
    logic [CO_W-1:0]  r_x_a;
    logic [AW-1:0]    r_addr;
    logic [PA_W-1:0]  zy_full;
    logic [PB_W-1:0]  addr_full;

    assign zy_full   = PA_W'(i_z) * PA_W'(i_size_y) + PA_W'(i_y);
    assign addr_full = PB_W'(r_zy) * PB_W'(i_size_x) + PB_W'(r_x_a);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_a <= '0;
            r_slot_b <= '0;
        end else begin
            r_slot_a <= i_slot;
            r_slot_b <= r_slot_a;
        end
    end

    always_ff @(posedge i_clk) begin
        r_zy   <= zy_full[ZY_W-1:0];
        r_x_a  <= i_x;
        r_addr <= addr_full[AW-1:0];
    end

    assign o_slot = r_slot_b;
    assign o_addr = r_addr;

endmodule

// ----- hw/rtl/gtl_lerp.sv -----
// Pairwise lerp reducer: takes a stream of values, lerps each pair by t,
// truncating toward zero. Depends on gtl_pkg.
module gtl_lerp #(
    parameter int FRAC_BITS = gtl_pkg::FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic signed [15:0]   i_value,
    input  logic [FRAC_BITS-1:0] i_t,
    output logic                 o_valid,
    output logic signed [15:0]   o_value
);
    import gtl_pkg::*;

    localparam int SW = 18 + FRAC_BITS;
    localparam logic signed [SW-1:0] RND = SW'((1 << FRAC_BITS) - 1);

    logic                    r_have;
    logic signed [15:0]      r_a;
    logic                    r_s1_v;
    logic signed [15:0]      r_a1;
    logic signed [SW-1:0]    r_prod;
    logic                    r_out_v;
    logic signed [15:0]      r_out;

    logic signed [16:0]      diff;
    logic signed [FRAC_BITS:0] t_s;
    logic signed [SW-1:0]    prod;
    logic signed [SW-1:0]    a_scaled;
    logic signed [SW-1:0]    sum;
    logic signed [SW-1:0]    sum_c;
    logic signed [SW-1:0]    quo;
    logic                    fire;

    assign fire = i_valid && r_have;
    assign diff = {i_value[15], i_value} - {r_a[15], r_a};
    assign t_s  = {1'b0, i_t};
    assign prod = diff * t_s;

    // a*ONE + (b-a)*t, then divide by ONE toward zero
    assign a_scaled = {{(SW-16){r_a1[15]}}, r_a1} <<< FRAC_BITS;
    assign sum      = a_scaled + r_prod;
    assign sum_c    = sum[SW-1] ? (sum + RND) : sum;
    assign quo      = sum_c >>> FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have  <= 1'b0;
            r_s1_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (i_valid) begin
                r_have <= !r_have;
            end
            r_s1_v  <= fire;
            r_out_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !r_have) begin
            r_a <= i_value;
        end
        if (fire) begin
            r_a1   <= r_a;
            r_prod <= prod;
        end
        if (r_s1_v) begin
            r_out <= quo[15:0];
        end
    end

    assign o_valid = r_out_v;
    assign o_value = r_out;

endmodule

// ----- hw/rtl/grid3d_trilinear_sampler_top.sv -----
// Top level of the 3D grid trilinear sampler: control, grid stores, lerp chain.
// Depends on gtl_pkg, gtl_ram, gtl_agen and gtl_lerp.

// A write beat stores density, material and zone of one cell. A sample beat
// stalls the input from acceptance until its result sits in the output
// register: nine reads (eight corners, then the nearest cell) go one per
// cycle through the shared two-stage address multiplier into the grid
// memories, and the corner densities then pass three chained lerp units
// (x, y, z). A waiting result does not block the next beat; only a second
// finished result waits for the output register to drain. The stores hold
// MAX_DIM^3 cells and are not cleared; cells must be written before they
// are sampled.
module grid3d_trilinear_sampler_top #(
    parameter int MAX_DIM   = gtl_pkg::MAX_DIM_DEF,
    parameter int FRAC_BITS = gtl_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [gtl_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [gtl_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  gtl_pkg::t_gtl_in                   i_in_item,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output gtl_pkg::t_gtl_out                  o_out_item
);
    import gtl_pkg::*;

    localparam int CO_W  = $clog2(MAX_DIM);
    localparam int SZ_W  = $clog2(MAX_DIM + 1);
    localparam int DEPTH = MAX_DIM * MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam logic signed [17:0] HALF = 18'(1 << (FRAC_BITS - 1));

    function automatic logic [SZ_W-1:0] eff_size(input logic [CFG_DATA_W-1:0] v);
        logic [SZ_W-1:0] r;
        if (v == '0) begin
            r = SZ_W'(1);
        end else if (32'(v) > MAX_DIM) begin
            r = SZ_W'(MAX_DIM);
        end else begin
            r = SZ_W'(v);
        end
        return r;
    endfunction

    function automatic logic [CO_W-1:0] clamp_c(input logic signed [17:0] v,
                                                input logic [SZ_W-1:0] n);
        logic signed [17:0] lim;
        logic [CO_W-1:0]    r;
        lim = $signed({{(18-SZ_W){1'b0}}, n}) - 18'sd1;
        if (v < 0) begin
            r = '0;
        end else if (v > lim) begin
            r = lim[CO_W-1:0];
        end else begin
            r = v[CO_W-1:0];
        end
        return r;
    endfunction

    // control
    t_gtl_state             r_state, n_state;
    logic [SLOT_W-1:0]      r_slot;
    logic [SZ_W-1:0]        r_size [3];
    logic [CO_W-1:0]        r_c0 [3];
    logic [CO_W-1:0]        r_c1 [3];
    logic [CO_W-1:0]        r_cr [3];
    logic [FRAC_BITS-1:0]   r_t [3];
    t_gtl_slot              r_rd_slot;
    logic signed [15:0]     r_res_density;
    logic [ATTR_W-1:0]      r_res_attr;
    logic                   r_out_valid;
    t_gtl_out               r_out_item;

    logic                   accept;
    logic                   issue;
    logic                   out_load;
    logic                   wr_en;
    logic [31:0]            wr_idx;

    logic signed [15:0]     pos [3];
    logic signed [16:0]     pe [3];
    logic signed [16:0]     fl [3];
    logic signed [17:0]     rnd [3];
    logic [CO_W-1:0]        n_c0 [3];
    logic [CO_W-1:0]        n_c1 [3];
    logic [CO_W-1:0]        n_cr [3];

    t_gtl_slot              issue_slot;
    logic [CO_W-1:0]        sel_x, sel_y, sel_z;
    t_gtl_slot              ag_slot;
    logic [AW-1:0]          ag_addr;
    logic [DENS_W-1:0]      dens_rdata;
    logic [ATTR_W-1:0]      attr_rdata;

    logic                   xv, yv, zv;
    logic signed [15:0]     xval, yval, zval;
    logic                   corner_v;

    assign accept = i_in_valid && !o_in_stall;
    assign wr_idx = 32'(i_in_item.cell_index);
    assign wr_en  = accept && (i_in_item.func == FUNC_WRITE) && (wr_idx < 32'(DEPTH));

    // per-axis base cell, neighbor, weight and nearest cell
    assign pos[0] = i_in_item.pos_x;
    assign pos[1] = i_in_item.pos_y;
    assign pos[2] = i_in_item.pos_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pe[i]   = {pos[i][15], pos[i]};
            fl[i]   = pe[i] >>> FRAC_BITS;
            rnd[i]  = ($signed({pe[i][16], pe[i]}) + HALF) >>> FRAC_BITS;
            n_c0[i] = clamp_c({fl[i][16], fl[i]}, r_size[i]);
            n_c1[i] = clamp_c({fl[i][16], fl[i]} + 18'sd1, r_size[i]);
            n_cr[i] = clamp_c(rnd[i], r_size[i]);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && (i_in_item.func == FUNC_SAMPLE)) begin
                    n_state = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                if (r_slot == SLOT_NEAREST) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (zv) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_stall = 1'b1;
        issue      = 1'b0;
        out_load   = 1'b0;
        case (r_state)
            ST_IDLE:  o_in_stall = 1'b0;
            ST_ISSUE: issue = 1'b1;
            ST_WAIT:  ;
            ST_DONE:  out_load = !r_out_valid || !i_out_stall;
            default:  o_in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_slot      <= '0;
            r_rd_slot   <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_size[i] <= eff_size(SIZE_RESET);
            end
        end else begin
            r_state   <= n_state;
            r_rd_slot <= ag_slot;
            if (issue) begin
                r_slot <= r_slot + SLOT_W'(1);
            end else begin
                r_slot <= '0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SIZE_X: r_size[0] <= eff_size(i_cfg_data);
                    CFG_SIZE_Y: r_size[1] <= eff_size(i_cfg_data);
                    CFG_SIZE_Z: r_size[2] <= eff_size(i_cfg_data);
                    default:    ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int i = 0; i < 3; i++) begin
                r_c0[i] <= n_c0[i];
                r_c1[i] <= n_c1[i];
                r_cr[i] <= n_cr[i];
                r_t[i]  <= pos[i][FRAC_BITS-1:0];
            end
        end
        if (r_rd_slot.valid && r_rd_slot.nearest) begin
            r_res_attr <= attr_rdata;
        end
        if (zv) begin
            r_res_density <= zval;
        end
        if (out_load) begin
            r_out_item.density  <= r_res_density;
            r_out_item.material <= r_res_attr[ATTR_W-1:16];
            r_out_item.zone     <= r_res_attr[15:0];
        end
    end

    // corner i takes the upper neighbor on x, y, z from bits 0, 1, 2
    always_comb begin
        issue_slot.valid   = issue;
        issue_slot.nearest = (r_slot == SLOT_NEAREST);
        if (issue_slot.nearest) begin
            sel_x = r_cr[0];
            sel_y = r_cr[1];
            sel_z = r_cr[2];
        end else begin
            sel_x = r_slot[0] ? r_c1[0] : r_c0[0];
            sel_y = r_slot[1] ? r_c1[1] : r_c0[1];
            sel_z = r_slot[2] ? r_c1[2] : r_c0[2];
        end
    end

    gtl_agen #(
        .MAX_DIM (MAX_DIM)
    ) u_agen (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_slot   (issue_slot),
        .i_x      (sel_x),
        .i_y      (sel_y),
        .i_z      (sel_z),
        .i_size_x (r_size[0]),
        .i_size_y (r_size[1]),
        .o_slot   (ag_slot),
        .o_addr   (ag_addr)
    );

    gtl_ram #(
        .WIDTH (DENS_W),
        .DEPTH (DEPTH)
    ) u_dens_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_idx[AW-1:0]),
        .i_wdata (i_in_item.write_density),
        .i_raddr (ag_addr),
        .o_rdata (dens_rdata)
    );

    gtl_ram #(
        .WIDTH (ATTR_W),
        .DEPTH (DEPTH)
    ) u_attr_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_idx[AW-1:0]),
        .i_wdata ({i_in_item.write_material, i_in_item.write_zone}),
        .i_raddr (ag_addr),
        .o_rdata (attr_rdata)
    );

    assign corner_v = r_rd_slot.valid && !r_rd_slot.nearest;

    gtl_lerp #(.FRAC_BITS (FRAC_BITS)) u_lerp_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (corner_v),
        .i_value ($signed(dens_rdata)),
        .i_t     (r_t[0]),
        .o_valid (xv),
        .o_value (xval)
    );

    gtl_lerp #(.FRAC_BITS (FRAC_BITS)) u_lerp_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (xv),
        .i_value (xval),
        .i_t     (r_t[1]),
        .o_valid (yv),
        .o_value (yval)
    );

    gtl_lerp #(.FRAC_BITS (FRAC_BITS)) u_lerp_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (yv),
        .i_value (yval),
        .i_t     (r_t[2]),
        .o_valid (zv),
        .o_value (zval)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ----- tb/gtl_sample_checker.sv -----
`timescale 1ns / 100ps
// Result checker for the 3D grid trilinear sampler: keeps its own copy of the
// grid stores and size registers, predicts every sample beat, compares results.
// Depends on gtl_pkg.
module gtl_sample_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [gtl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [gtl_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  gtl_pkg::t_gtl_in               i_in_item,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  gtl_pkg::t_gtl_out              i_out_item,
    output int                             o_mismatches,
    output int                             o_outstanding
);
    import gtl_pkg::*;

    localparam int MAX_DIM      = MAX_DIM_DEF;
    localparam int FRAC         = FRAC_BITS_DEF;
    localparam int ONE_FX       = 1 << FRAC;
    localparam int STORE_DEPTH  = MAX_DIM * MAX_DIM * MAX_DIM;
    localparam int REPORT_LIMIT = 10;

    logic signed [15:0]    dens_cells [STORE_DEPTH];
    logic [7:0]            mat_cells  [STORE_DEPTH];
    logic signed [15:0]    zone_cells [STORE_DEPTH];
    logic [CFG_DATA_W-1:0] size_x_q, size_y_q, size_z_q;
    t_gtl_out              sample_results_q [$];
    t_gtl_out              want;
    int                    mismatch_cnt = 0;

    // zero reads as one, anything past the store edge saturates
    function automatic int grid_dim(input logic [CFG_DATA_W-1:0] raw);
        if (raw == 0) return 1;
        if (raw > MAX_DIM) return MAX_DIM;
        return int'(raw);
    endfunction

    function automatic int clamp_cell(input int v, input int n);
        if (v < 0) return 0;
        if (v > n - 1) return n - 1;
        return v;
    endfunction

    function automatic int cell_addr(input int x, input int y, input int z,
                                     input int sx, input int sy);
        return (z * sy + y) * sx + x;
    endfunction

    // weighted blend, truncated toward zero
    function automatic int lerp_fx(input int a, input int b, input int t);
        longint acc;
        acc = longint'(a) * longint'(ONE_FX - t) + longint'(b) * longint'(t);
        return int'(acc / longint'(ONE_FX));
    endfunction

    function automatic t_gtl_out predict_sample(input t_gtl_in beat);
        int dim [3];
        int pos [3];
        int lo [3];
        int hi [3];
        int frac [3];
        int near [3];
        int corner [8];
        int along_x [4];
        int along_y [2];
        int at;
        t_gtl_out res;
        dim[0] = grid_dim(size_x_q);
        dim[1] = grid_dim(size_y_q);
        dim[2] = grid_dim(size_z_q);
        pos[0] = $signed(beat.pos_x);
        pos[1] = $signed(beat.pos_y);
        pos[2] = $signed(beat.pos_z);
        for (int k = 0; k < 3; k++) begin
            lo[k]   = clamp_cell(pos[k] >>> FRAC, dim[k]);
            hi[k]   = clamp_cell((pos[k] >>> FRAC) + 1, dim[k]);
            frac[k] = pos[k] & (ONE_FX - 1);
            near[k] = clamp_cell((pos[k] + ONE_FX / 2) >>> FRAC, dim[k]);
        end
        // corner i: bit 0 picks x, bit 1 picks y, bit 2 picks z
        for (int i = 0; i < 8; i++) begin
            at = cell_addr((i & 1) ? hi[0] : lo[0], (i & 2) ? hi[1] : lo[1],
                           (i & 4) ? hi[2] : lo[2], dim[0], dim[1]);
            corner[i] = dens_cells[at];
        end
        for (int i = 0; i < 4; i++)
            along_x[i] = lerp_fx(corner[2*i], corner[2*i+1], frac[0]);
        for (int i = 0; i < 2; i++)
            along_y[i] = lerp_fx(along_x[2*i], along_x[2*i+1], frac[1]);
        at = cell_addr(near[0], near[1], near[2], dim[0], dim[1]);
        res.density  = 16'(lerp_fx(along_y[0], along_y[1], frac[2]));
        res.material = mat_cells[at];
        res.zone     = zone_cells[at];
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            size_x_q = SIZE_RESET;
            size_y_q = SIZE_RESET;
            size_z_q = SIZE_RESET;
            sample_results_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SIZE_X: size_x_q = i_cfg_data;
                    CFG_SIZE_Y: size_y_q = i_cfg_data;
                    CFG_SIZE_Z: size_z_q = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (sample_results_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= REPORT_LIMIT)
                        $display("%0t: result with none expected: %s %0d %s %0d %s %0d",
                                 $time, "density", i_out_item.density,
                                 "material", i_out_item.material,
                                 "zone", i_out_item.zone);
                end else begin
                    want = sample_results_q.pop_front();
                    if (i_out_item.density !== want.density ||
                        i_out_item.material !== want.material ||
                        i_out_item.zone !== want.zone) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= REPORT_LIMIT)
                            $display({"%0t: expected density %0d material %0d zone %0d,",
                                      " got density %0d material %0d zone %0d"},
                                     $time, want.density, want.material, want.zone,
                                     i_out_item.density, i_out_item.material,
                                     i_out_item.zone);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_in_item.func == FUNC_SAMPLE) begin
                    sample_results_q = {sample_results_q, predict_sample(i_in_item)};
                end else if (i_in_item.cell_index < STORE_DEPTH) begin
                    dens_cells[i_in_item.cell_index] = i_in_item.write_density;
                    mat_cells[i_in_item.cell_index]  = i_in_item.write_material;
                    zone_cells[i_in_item.cell_index] = i_in_item.write_zone;
                end
            end
        end
        o_mismatches  <= mismatch_cnt;
        o_outstanding <= sample_results_q.size();
    end

endmodule

// ----- tb/grid3d_trilinear_sampler_top_tb.sv -----
`timescale 1ns / 100ps
// Testbench top for the 3D grid trilinear sampler: clock, reset, size
// programming, write/sample beats, output stall pattern and verdict.
// Depends on gtl_pkg, grid3d_trilinear_sampler_top and gtl_sample_checker.
module grid3d_trilinear_sampler_top_tb;
    import gtl_pkg::*;

    localparam int ONE_FX          = 1 << FRAC_BITS_DEF;
    localparam int CELL_MAX        = MAX_DIM_DEF - 1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int SETTLE_CYCLES   = 40;
    localparam int HOLD_CYCLES     = 400;
    localparam int HOLD_AFTER      = 30;
    localparam int QUIET_LIMIT     = 4000;
    localparam int RANDOM_PHASES   = 7;
    localparam int MIXED_BEATS     = 30;
    localparam int CLUSTERS        = 6;
    localparam int CLUSTER_SAMPLES = 5;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    t_gtl_in               in_item   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_gtl_out              out_item;
    int                    mismatches;
    int                    outstanding;

    int ex, ey, ez;          // grid extents currently in use
    int burst_left   = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;
    int results_seen = 0;
    int rx_tick      = 0;

    wire any_beat = (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    grid3d_trilinear_sampler_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    gtl_sample_checker sample_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in_item     (in_item),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out_item    (out_item),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    // Output side: stall mode follows bits 8:7 of a free-running tick; one long hold-off
    // once results are flowing, so the block backs up into its input.
    always @(posedge clk) begin
        rx_tick <= rx_tick + 1;
        if (out_valid && !out_stall)
            results_seen <= results_seen + 1;
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else if (!hold_done && results_seen >= HOLD_AFTER && in_valid) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end else begin
            case (rx_tick[8:7])
                2'd0:    out_stall <= 1'b0;
                2'd1:    out_stall <= ($urandom_range(0, 3) == 0);
                2'd2:    out_stall <= ($urandom_range(0, 3) != 0);
                default: out_stall <= rx_tick[2];
            endcase
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if (any_beat || !rst_n)
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL");
        $finish;
    end

    function automatic int extent(input logic [CFG_DATA_W-1:0] raw);
        if (raw == 0) return 1;
        if (raw > MAX_DIM_DEF) return MAX_DIM_DEF;
        return int'(raw);
    endfunction

    function automatic logic [14:0] grid_index(input int x, input int y, input int z);
        return 15'((z * ey + y) * ex + x);
    endfunction

    function automatic int cell_step(input int b, input int d);
        return (b + d > CELL_MAX) ? CELL_MAX : b + d;
    endfunction

    // mostly around the grid, sometimes anywhere in the 16-bit range
    function automatic logic [15:0] pick_coord(input int e);
        if ($urandom_range(0, 3) == 0)
            return 16'($urandom);
        return 16'(int'($urandom_range(0, (e + 2) * ONE_FX + ONE_FX - 1)) - 2 * ONE_FX);
    endfunction

    function automatic t_gtl_in make_write(input logic [14:0] idx, input logic [15:0] dens,
                                           input logic [7:0] mat, input logic [15:0] zone);
        t_gtl_in beat;
        beat.func           = FUNC_WRITE;
        beat.cell_index     = idx;
        beat.write_density  = dens;
        beat.write_material = mat;
        beat.write_zone     = zone;
        beat.pos_x          = 16'($urandom);
        beat.pos_y          = 16'($urandom);
        beat.pos_z          = 16'($urandom);
        return beat;
    endfunction

    function automatic t_gtl_in make_sample(input logic [15:0] px, input logic [15:0] py,
                                            input logic [15:0] pz);
        t_gtl_in beat;
        beat.func           = FUNC_SAMPLE;
        beat.cell_index     = 15'($urandom);
        beat.write_density  = 16'($urandom);
        beat.write_material = 8'($urandom);
        beat.write_zone     = 16'($urandom);
        beat.pos_x          = px;
        beat.pos_y          = py;
        beat.pos_z          = pz;
        return beat;
    endfunction

    task automatic send_beat(input t_gtl_in beat);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        in_valid <= 1'b1;
        in_item  <= beat;
        do @(posedge clk); while (in_stall);
        burst_left--;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_grid(input logic [CFG_DATA_W-1:0] rx, input logic [CFG_DATA_W-1:0] ry,
                                input logic [CFG_DATA_W-1:0] rz);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SIZE_X;
        cfg_data  <= rx;
        @(posedge clk);
        cfg_index <= CFG_SIZE_Y;
        cfg_data  <= ry;
        @(posedge clk);
        cfg_index <= CFG_SIZE_Z;
        cfg_data  <= rz;
        @(posedge clk);
        // no register behind this index; the write must change nothing
        cfg_index <= CFG_SPARE;
        cfg_data  <= CFG_DATA_W'($urandom);
        @(posedge clk);
        cfg_we <= 1'b0;
        ex = extent(rx);
        ey = extent(ry);
        ez = extent(rz);
    endtask

    initial begin : stimulus
        logic [CFG_DATA_W-1:0] rx, ry, rz;
        int r, bx, by, bz;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // 2x2x2 grid, corner i at index i, with the density extremes
        program_grid(6'd2, 6'd2, 6'd2);
        send_beat(make_write(15'd0, 16'h7FFF, 8'hFF, 16'h7FFF));
        send_beat(make_write(15'd1, 16'h8000, 8'h00, 16'h8000));
        send_beat(make_write(15'd2, 16'h0000, 8'h5A, 16'h0000));
        send_beat(make_write(15'd3, 16'hFFFF, 8'hA5, 16'hFFFF));
        send_beat(make_write(15'd4, 16'h0100, 8'h01, 16'h04D2));
        send_beat(make_write(15'd5, 16'hFF00, 8'h02, 16'hFB2E));
        send_beat(make_write(15'd6, 16'h0001, 8'h80, 16'h5555));
        send_beat(make_write(15'd7, 16'h3039, 8'h7F, 16'hAAAA));
        send_beat(make_sample(16'h0000, 16'h0000, 16'h0000));
        send_beat(make_sample(16'h7FFF, 16'h7FFF, 16'h7FFF));   // clamp high
        send_beat(make_sample(16'h8000, 16'h8000, 16'h8000));   // clamp low
        send_beat(make_sample(16'h0080, 16'h0080, 16'h0080));   // nearest: half rounds up
        send_beat(make_sample(16'h007F, 16'h007F, 16'h007F));
        send_beat(make_sample(16'hFF80, 16'hFF80, 16'hFF80));
        send_beat(make_sample(16'hFF7F, 16'hFF7F, 16'hFF7F));
        // max and min blended at one half: negative half truncates to zero
        send_beat(make_sample(16'h0080, 16'h0000, 16'h0000));
        send_beat(make_sample(16'h00FF, 16'h0001, 16'h00FE));
        send_beat(make_sample(16'h0100, 16'h0000, 16'h01FF));
        send_beat(make_sample(16'h0180, 16'hFFFF, 16'h00C8));
        send_beat(make_sample(16'h0064, 16'h00C8, 16'h012C));
        // overwrite a cell and read it straight back
        send_beat(make_write(15'd7, 16'h8000, 8'h33, 16'h1234));
        send_beat(make_sample(16'h0100, 16'h0100, 16'h0100));
        // outside the grid in use but inside the store
        send_beat(make_write(15'h7FFF, 16'h1111, 8'h22, 16'h3333));
        send_beat(make_sample(16'h00C0, 16'h0040, 16'h00A0));

        // small grids, sizes zero and above the maximum among them
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: begin rx = 6'd63; ry = 6'd1;  rz = 6'd0;  end
                1: begin rx = 6'd0;  ry = 6'd33; rz = 6'd1;  end
                2: begin rx = 6'd1;  ry = 6'd0;  rz = 6'd32; end
                3: begin rx = 6'd3;  ry = 6'd4;  rz = 6'd2;  end
                4: begin rx = 6'd5;  ry = 6'd1;  rz = 6'd3;  end
                default: begin
                    rx = CFG_DATA_W'($urandom_range(0, 3));
                    ry = CFG_DATA_W'($urandom_range(0, 3));
                    rz = CFG_DATA_W'($urandom_range(0, 3));
                end
            endcase
            program_grid(rx, ry, rz);
            for (int z = 0; z < ez; z++)
                for (int y = 0; y < ey; y++)
                    for (int x = 0; x < ex; x++)
                        send_beat(make_write(grid_index(x, y, z), 16'($urandom),
                                             8'($urandom), 16'($urandom)));
            for (int n = 0; n < MIXED_BEATS; n++) begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    send_beat(make_sample(pick_coord(ex), pick_coord(ey), pick_coord(ez)));
                else if (r < 85)
                    send_beat(make_write(grid_index($urandom_range(0, ex - 1),
                                                    $urandom_range(0, ey - 1),
                                                    $urandom_range(0, ez - 1)),
                                         16'($urandom), 8'($urandom), 16'($urandom)));
                else
                    send_beat(make_write(15'($urandom), 16'($urandom), 8'($urandom),
                                         16'($urandom)));
            end
        end

        // full-size grid; only small clusters are written, samples stay inside them
        program_grid(6'd32, 6'd63, 6'd33);
        for (int c = 0; c < CLUSTERS; c++) begin
            bx = (c == 0) ? 0 : (c == 1) ? CELL_MAX : $urandom_range(0, CELL_MAX);
            by = (c == 0) ? 0 : (c == 1) ? CELL_MAX : $urandom_range(0, CELL_MAX);
            bz = (c == 0) ? 0 : (c == 1) ? CELL_MAX : $urandom_range(0, CELL_MAX);
            for (int k = 0; k < 8; k++)
                send_beat(make_write(grid_index(cell_step(bx, k & 1), cell_step(by, (k >> 1) & 1),
                                                cell_step(bz, (k >> 2) & 1)),
                                     16'($urandom), 8'($urandom), 16'($urandom)));
            for (int n = 0; n < CLUSTER_SAMPLES; n++)
                send_beat(make_sample(16'(bx * ONE_FX + $urandom_range(0, ONE_FX - 1)),
                                      16'(by * ONE_FX + $urandom_range(0, ONE_FX - 1)),
                                      16'(bz * ONE_FX + $urandom_range(0, ONE_FX - 1))));
        end

        settle();
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
